// ===== rtl/wbps_pkg.sv =====
// Shared constants and types for the wildcard byte pattern scanner.
`default_nettype none

package wbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int OFFSET_BITS       = 32;

  localparam int BYTE_W     = 8;
  localparam int OUT_W      = 32;
  localparam int LEN_W      = 5;
  localparam int LEN_IDX_W  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int SEEN_W     = OFFSET_BITS + 1;
  localparam int REPORT_W   = (OFFSET_BITS < OUT_W) ? OFFSET_BITS : OUT_W;
  localparam int CARE_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO = 3'd0,
    REG_PAT_HI = 3'd1,
    REG_CARE   = 3'd2,
    REG_LEN    = 3'd3
  } cfg_reg_e;

  // Shift control shared by every window cell.
  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/wbps_cell.sv =====
// One window cell: holds a byte, passes it on, compares it with its pattern byte.
`default_nettype none

module wbps_cell
  import wbps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [BYTE_W-1:0] pat_i,
  input  logic              care_i,
  output logic [BYTE_W-1:0] byte_o,
  output logic              hit_o
);

  logic [BYTE_W-1:0] byte_q, byte_d;

  // Compare the byte this cell takes in on the shift, combinationally.
  assign hit_o = !care_i || (byte_i == pat_i);

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.advance) begin
      byte_d = ctl_i.clear ? '0 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

// ===== rtl/wbps_out_buf.sv =====
// Output register with a skid stage for match offsets.
`default_nettype none

module wbps_out_buf
  import wbps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [OUT_W-1:0] data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [OUT_W-1:0] out_data_o
);

  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_data_q, out_data_d;
  logic             skid_valid_q, skid_valid_d;
  logic [OUT_W-1:0] skid_data_q, skid_data_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // drain skid first; no push can arrive while it is full
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        if (push_i) begin
          out_data_d = data_i;
        end
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds data while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("push while skid stage is full");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid stage failed to drain");

endmodule

`default_nettype wire

// ===== rtl/wbps_top.sv =====
// Top level of the wildcard byte pattern scanner: window chain, offset counter, config.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | stream_byte_i, end_of_buffer_i
//  out     | source    | out_valid_o / out_stall_i | match_offset_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One byte per cycle while in_stall_o is low: each accepted byte shifts the cell chain
//  and the match is decided in that same cycle; out carries the registered offset.
//  Reset clears the window, the offset counter and the output stages, and
//  loads the care mask and pattern length with 1.
//  A stalled out channel fills the skid stage; in_stall_o rises only then.
//  cfg_ready_o is always high.
`default_nettype none

module wildcard_byte_pattern_scanner_top
  import wbps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [BYTE_W-1:0]     stream_byte_i,
  input  logic                  end_of_buffer_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OUT_W-1:0]      match_offset_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pat_lo_q, pat_hi_q;
  logic [CARE_W-1:0]     care_q;
  logic [LEN_W-1:0]      len_q;

  // Window chain.
  cell_ctl_t                                   cell_ctl;
  logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0]    cell_in;
  logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0]    cell_byte;
  logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0]    cell_pat;
  logic [MAX_PATTERN_BYTES-1:0]                cell_care;
  logic [MAX_PATTERN_BYTES-1:0]                cell_hit;
  logic [2*CFG_DATA_W/BYTE_W-1:0][BYTE_W-1:0]  pat_all;

  // Buffer position.
  logic [SEEN_W-1:0]    seen_q, seen_d;
  logic [SEEN_W-1:0]    start_ofs;
  logic [LEN_IDX_W-1:0] len_m1;
  logic                 in_acc;
  logic                 full_window;
  logic                 hit;
  logic                 push;
  logic                 buf_full;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign in_acc      = in_valid_i && !buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= CARE_W'(1);
      len_q    <= LEN_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PAT_LO: pat_lo_q <= cfg_data_i;
        REG_PAT_HI: pat_hi_q <= cfg_data_i;
        REG_CARE:   care_q   <= cfg_data_i[CARE_W-1:0];
        REG_LEN:    len_q    <= cfg_data_i[LEN_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp the length: zero acts as one, anything past the window as full width.
  always_comb begin
    if (len_q == '0) begin
      len_m1 = '0;
    end else if (len_q > LEN_W'(MAX_PATTERN_BYTES)) begin
      len_m1 = LEN_IDX_W'(MAX_PATTERN_BYTES - 1);
    end else begin
      len_m1 = LEN_IDX_W'(len_q - LEN_W'(1));
    end
  end

  assign pat_all = {pat_hi_q, pat_lo_q};

  // Cell k holds the k-th newest byte; it lines up with pattern byte len-1-k.
  // Cells past the length see no care bit and always hit.
  always_comb begin
    logic [LEN_IDX_W-1:0] sel;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      sel = len_m1 - LEN_IDX_W'(k);
      if (LEN_IDX_W'(k) <= len_m1) begin
        cell_pat[k]  = pat_all[sel];
        cell_care[k] = care_q[sel];
      end else begin
        cell_pat[k]  = '0;
        cell_care[k] = 1'b0;
      end
    end
  end

  assign cell_ctl.advance = in_acc;
  assign cell_ctl.clear   = end_of_buffer_i;

  // Feed the newest byte into cell 0; each cell feeds its older neighbor.
  always_comb begin
    cell_in[0] = stream_byte_i;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      cell_in[k] = cell_byte[k-1];
    end
  end

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    wbps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl),
      .byte_i (cell_in[k]),
      .pat_i  (cell_pat[k]),
      .care_i (cell_care[k]),
      .byte_o (cell_byte[k]),
      .hit_o  (cell_hit[k])
    );
  end

  // seen_q counts earlier bytes of this buffer, so the window is full once
  // seen_q + 1 >= len. A saturated count gives a start offset past the
  // reportable range, which silences the rest of the buffer.
  assign full_window = seen_q >= SEEN_W'(len_m1);
  assign start_ofs   = seen_q - SEEN_W'(len_m1);
  assign hit         = &cell_hit;
  assign push        = in_acc && hit && full_window && (start_ofs[SEEN_W-1:REPORT_W] == '0);

  always_comb begin
    seen_d = seen_q;
    if (in_acc) begin
      if (end_of_buffer_i) begin
        seen_d = '0;
      end else if (seen_q != '1) begin
        seen_d = seen_q + SEEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  wbps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (OUT_W'(start_ofs[REPORT_W-1:0])),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (match_offset_o)
  );

  a_eob_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_buffer_i) |=> (seen_q == '0 && cell_byte[0] == '0))
    else $error("buffer end did not restart position and window");

  a_count_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !end_of_buffer_i && seen_q != '1) |=> (seen_q == $past(seen_q) + SEEN_W'(1)))
    else $error("byte counter failed to advance");

  a_no_early_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> full_window)
    else $error("match reported before the window was full");

endmodule

`default_nettype wire
